// ===== hdl/llur_pkg.sv =====
// ----------------------------------------------------------------------------
// llur_pkg
// Shared constants and types for the exponential random generator: the
// generator constants, fixed-point formats and the divider request bundle.
// ----------------------------------------------------------------------------
package llur_pkg;

    localparam int RANGE_W              = 16;
    localparam int VALUE_W              = 32;
    localparam int STATE_W              = 32;
    localparam int OUTPUT_FRACTION_BITS = 16;

    localparam logic [STATE_W-1:0] LCG_MUL     = 32'd2891336453;
    localparam logic [STATE_W-1:0] LCG_ADD     = 32'd1500450271;
    localparam logic [STATE_W-1:0] STATE_MASK  = 32'h7fff_ffff;
    localparam logic [STATE_W-1:0] STATE_RESET = 32'd2076571060;
    localparam logic [31:0]        DIVISOR     = 32'd2147483647;

    localparam logic [RANGE_W-1:0] RANGE_ONE = 16'd1;

    // Q62 fixed point is carried in 64-bit words.
    localparam int             Q_W     = 64;
    localparam logic [Q_W-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    localparam int SERIES_TERMS = 24;
    localparam int SQUARINGS    = 6;
    localparam int N_W          = $clog2(SERIES_TERMS + 1);
    localparam int SQ_W         = $clog2(SQUARINGS);

    // Five passes through the multiplier make one Q62 product.
    localparam int MUL_STEPS = 5;
    localparam int SUB_W     = $clog2(MUL_STEPS);

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_DIGITS = 8;
    localparam int DIV_CYCLES = Q_W / DIV_DIGITS;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    // Final scaling: range times the Q62 value, reduced to the output format.
    localparam int VSUM_W    = 48;
    localparam int VAL_SHIFT = 30 - OUTPUT_FRACTION_BITS;

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] dividend;
        logic [N_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== hdl/lcg_log_uniform_random.sv =====
// ----------------------------------------------------------------------------
// lcg_log_uniform_random
// Exponentially distributed random generator. A draw steps a linear
// congruential state and returns range * exp(-range * s / (2^31 - 1)) in
// unsigned Q16.16, via a Taylor series in Q62 and six squarings.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_stall     i_operation, i_seed_value
//   result    out        o_out_valid / i_out_stall   o_value_q16
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (range)
//
// A seed transaction loads the state and produces no result. A draw returns
// its result after 24 series terms, each of 5 multiplier passes and a divide,
// 6 squarings of 5 passes, and the setup and scaling steps. The next
// transaction is taken once the block is back in idle.
// All multiplies run through the one 32 x 32 multiplier and all divides through the one divider.
// Reset is synchronous and active low; no clearing pass follows it.
// A stalled result waits in the output register; the next draw is accepted
// meanwhile and holds in its last step until that register frees up.
// ----------------------------------------------------------------------------
module lcg_log_uniform_random
    import llur_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_operation,
    input  logic signed [STATE_W-1:0] i_seed_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [VALUE_W-1:0]        o_value_q16,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [RANGE_W-1:0]        i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LCG    = 4'd1;
    localparam logic [3:0] S_SCALE  = 4'd2;
    localparam logic [3:0] S_TMUL   = 4'd3;
    localparam logic [3:0] S_QR     = 4'd4;
    localparam logic [3:0] S_FRAC   = 4'd5;
    localparam logic [3:0] S_CFRAC  = 4'd6;
    localparam logic [3:0] S_YSUM   = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DWAIT  = 4'd10;
    localparam logic [3:0] S_FL     = 4'd11;
    localparam logic [3:0] S_FH     = 4'd12;
    localparam logic [3:0] S_FV     = 4'd13;
    localparam logic [3:0] S_CLAMP  = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    localparam int SUB_LAST = MUL_STEPS - 1;

    logic [3:0]         r_st,     n_st;
    logic [STATE_W-1:0] r_gen,    n_gen;
    logic [RANGE_W-1:0] r_range,  n_range;
    logic [4:0]         r_q5,     n_q5;
    logic               r_big,    n_big;
    logic [30:0]        r_r,      n_r;
    logic [31:0]        r_a,      n_a;
    logic [30:0]        r_b,      n_b;
    logic [24:0]        r_c,      n_c;
    logic [Q_W-1:0]     r_y,      n_y;
    logic [Q_W-1:0]     r_term,   n_term;
    logic [Q_W-1:0]     r_sum,    n_sum;
    logic [65:0]        r_acc,    n_acc;
    logic [Q_W-1:0]     r_mres,   n_mres;
    logic [N_W-1:0]     r_n,      n_n;
    logic               r_square, n_square;
    logic [SQ_W-1:0]    r_sqcnt,  n_sqcnt;
    logic [SUB_W-1:0]   r_sub,    n_sub;
    logic [31:0]        r_lo,     n_lo;
    logic [VSUM_W-1:0]  r_vsum,   n_vsum;
    logic [VALUE_W-1:0] r_val,    n_val;
    logic               r_out_valid, n_out_valid;

    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    mul_p;
    t_div_req       div_req;
    logic           div_done;
    logic [Q_W-1:0] div_quot;

    llur_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    llur_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic           in_take;
    logic           out_free;
    logic [Q_W-1:0] op_x;
    logic [Q_W-1:0] op_y;

    // Quotient and remainder of t by 2^31-1: t = hi*2^31 + lo = hi*D + hi + lo.
    logic [15:0] qr_hi;
    logic [30:0] qr_lo;
    logic [31:0] qr_s;
    logic        qr_ge;
    logic [16:0] qr_q;

    // r*2^32 = 2r*D + 2r, so the quotient and remainder follow from 2r.
    logic [31:0] fr_r2;
    logic        fr_ge;

    logic [23:0] cf_xh;
    logic [31:0] cf_s;

    logic [Q_W-1:0]    m_hi;
    logic [Q_W-1:0]    m_res;
    logic [VSUM_W-1:0] fv_sum;
    logic [VSUM_W-1:0] cl_top;

    assign in_take  = i_in_valid && (r_st == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign op_x = r_square ? r_sum : r_term;
    assign op_y = r_square ? r_sum : r_y;

    assign qr_hi = mul_p[46:31];
    assign qr_lo = mul_p[30:0];
    assign qr_s  = 32'(qr_hi) + 32'(qr_lo);
    assign qr_ge = (qr_s >= DIVISOR);
    assign qr_q  = 17'(qr_hi) + 17'(qr_ge);

    assign fr_r2 = {r_r, 1'b0};
    assign fr_ge = (fr_r2 >= DIVISOR);

    assign cf_xh = r_b[30:7];
    assign cf_s  = 32'(cf_xh) + {1'b0, r_b[6:0], 24'd0};

    // Fourth partial product closes the Q62 product; keep bits 62 and up.
    assign m_hi  = mul_p + 64'(r_acc[65:32]);
    assign m_res = {m_hi[61:0], r_acc[31:30]};

    assign fv_sum = VSUM_W'(mul_p) + VSUM_W'(r_lo);
    assign cl_top = VSUM_W'(r_range) << OUTPUT_FRACTION_BITS;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_st)
            S_LCG: begin
                mul_a = r_gen;
                mul_b = LCG_MUL;
            end
            S_TMUL: begin
                mul_a = 32'(r_range);
                mul_b = r_gen;
            end
            S_MUL: begin
                case (r_sub)
                    SUB_W'(0): begin
                        mul_a = op_x[31:0];
                        mul_b = op_y[31:0];
                    end
                    SUB_W'(1): begin
                        mul_a = op_x[31:0];
                        mul_b = op_y[63:32];
                    end
                    SUB_W'(2): begin
                        mul_a = op_x[63:32];
                        mul_b = op_y[31:0];
                    end
                    default: begin
                        mul_a = op_x[63:32];
                        mul_b = op_y[63:32];
                    end
                endcase
            end
            S_FL: begin
                mul_a = 32'(r_range);
                mul_b = r_sum[31:0];
            end
            S_FH: begin
                mul_a = 32'(r_range);
                mul_b = r_sum[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req          = '0;
        div_req.start    = (r_st == S_DSTART);
        div_req.dividend = r_mres;
        div_req.divisor  = r_n;
    end

    always_comb begin
        n_st        = r_st;
        n_gen       = r_gen;
        n_range     = r_range;
        n_q5        = r_q5;
        n_big       = r_big;
        n_r         = r_r;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_y         = r_y;
        n_term      = r_term;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_mres      = r_mres;
        n_n         = r_n;
        n_square    = r_square;
        n_sqcnt     = r_sqcnt;
        n_sub       = r_sub;
        n_lo        = r_lo;
        n_vsum      = r_vsum;
        n_val       = r_val;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_valid) begin
            n_range = (i_cfg_data == '0) ? RANGE_ONE : i_cfg_data;
        end

        unique case (r_st)
            S_IDLE: begin
                if (in_take) begin
                    if (i_operation) begin
                        n_gen = STATE_W'(i_seed_value);
                    end else begin
                        n_st = S_LCG;
                    end
                end
            end
            S_LCG: begin
                n_st = S_SCALE;
            end
            S_SCALE: begin
                n_gen = (mul_p[31:0] + LCG_ADD) & STATE_MASK;
                n_st  = S_TMUL;
            end
            S_TMUL: begin
                n_st = S_QR;
            end
            S_QR: begin
                n_q5  = qr_q[4:0];
                n_big = (qr_q[16:5] != '0);
                n_r   = qr_ge ? 31'(qr_s - DIVISOR) : 31'(qr_s);
                n_st  = S_FRAC;
            end
            S_FRAC: begin
                n_a = fr_r2 + 32'(fr_ge);
                n_b = fr_ge ? 31'(fr_r2 - DIVISOR) : 31'(fr_r2);
                if (r_big) begin
                    // The exponent is past 32: the true value is under one LSB.
                    n_vsum = '0;
                    n_st   = S_CLAMP;
                end else begin
                    n_st = S_CFRAC;
                end
            end
            S_CFRAC: begin
                n_c  = 25'(cf_xh) + 25'(cf_s >= DIVISOR);
                n_st = S_YSUM;
            end
            S_YSUM: begin
                n_y      = (64'(r_q5) << 56) + (64'(r_a) << 24) + 64'(r_c);
                n_term   = ONE_Q62;
                n_sum    = ONE_Q62;
                n_n      = N_W'(1);
                n_square = 1'b0;
                n_sqcnt  = '0;
                n_sub    = '0;
                n_st     = S_MUL;
            end
            S_MUL: begin
                n_sub = r_sub + 1'b1;
                case (r_sub)
                    SUB_W'(1): n_acc = 66'(mul_p[63:32]);
                    SUB_W'(2): n_acc = r_acc + 66'(mul_p);
                    SUB_W'(3): n_acc = r_acc + 66'(mul_p);
                    default:   n_acc = r_acc;
                endcase
                if (r_sub == SUB_W'(SUB_LAST)) begin
                    n_sub = '0;
                    if (r_square) begin
                        n_sum   = m_res;
                        n_sqcnt = r_sqcnt + 1'b1;
                        if (r_sqcnt == SQ_W'(SQUARINGS - 1)) begin
                            n_st = S_FL;
                        end
                    end else begin
                        n_mres = m_res;
                        n_st   = S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                n_st = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    n_term = div_quot;
                    // Odd powers of the series are subtracted.
                    n_sum  = r_n[0] ? (r_sum - div_quot) : (r_sum + div_quot);
                    n_st   = S_MUL;
                    if (r_n == N_W'(SERIES_TERMS)) begin
                        n_square = 1'b1;
                    end else begin
                        n_n = r_n + 1'b1;
                    end
                end
            end
            S_FL: begin
                n_st = S_FH;
            end
            S_FH: begin
                n_lo = mul_p[63:32];
                n_st = S_FV;
            end
            S_FV: begin
                n_vsum = fv_sum >> VAL_SHIFT;
                n_st   = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_vsum >= cl_top) begin
                    n_vsum = VSUM_W'(r_range - 1'b1) << OUTPUT_FRACTION_BITS;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                // The output register is loaded only once the last result has left.
                if (out_free) begin
                    n_val       = VALUE_W'(r_vsum);
                    n_out_valid = 1'b1;
                    n_st        = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_gen       <= STATE_RESET;
            r_range     <= RANGE_ONE;
            r_out_valid <= 1'b0;
            r_sub       <= '0;
            r_n         <= '0;
            r_square    <= 1'b0;
            r_sqcnt     <= '0;
        end else begin
            r_st        <= n_st;
            r_gen       <= n_gen;
            r_range     <= n_range;
            r_out_valid <= n_out_valid;
            r_sub       <= n_sub;
            r_n         <= n_n;
            r_square    <= n_square;
            r_sqcnt     <= n_sqcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q5   <= n_q5;
        r_big  <= n_big;
        r_r    <= n_r;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_y    <= n_y;
        r_term <= n_term;
        r_sum  <= n_sum;
        r_acc  <= n_acc;
        r_mres <= n_mres;
        r_lo   <= n_lo;
        r_vsum <= n_vsum;
        r_val  <= n_val;
    end

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value_q16 = r_val;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hdl/llur_mul.sv =====
// ----------------------------------------------------------------------------
// llur_mul
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module llur_mul
    import llur_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/llur_div.sv =====
// ----------------------------------------------------------------------------
// llur_div
// Iterative divider of a 64-bit value by a small series index. Restoring
// long division, several quotient bits per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module llur_div
    import llur_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_div_req       i_req,
    output logic           o_done,
    output logic [Q_W-1:0] o_quot
);

    logic [Q_W-1:0]    r_quot;
    logic [N_W-1:0]    r_rem;
    logic [N_W-1:0]    r_div;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [Q_W-1:0] c_quot;
    logic [N_W-1:0] c_rem;
    logic [N_W:0]   c_ext;

    always_comb begin
        c_quot = r_quot;
        c_rem  = r_rem;
        c_ext  = '0;
        for (int i = 0; i < DIV_DIGITS; i++) begin
            c_ext  = {c_rem, c_quot[Q_W-1]};
            c_quot = {c_quot[Q_W-2:0], 1'b0};
            if (c_ext >= {1'b0, r_div}) begin
                c_ext     = c_ext - {1'b0, r_div};
                c_quot[0] = 1'b1;
            end
            c_rem = c_ext[N_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quot <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quot <= c_quot;
                r_rem  <= c_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/llur_chk.sv =====
// ----------------------------------------------------------------------------
// llur_chk
// Port-level checks for the exponential random generator, bound to the top.
// ----------------------------------------------------------------------------
module llur_chk
    import llur_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_operation,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [VALUE_W-1:0] o_value_q16
);

    // A result that is held back keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value_q16))
        else $error("stalled result changed or was dropped");

    // A draw keeps the block busy for the following cycle.
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_operation |=> o_in_stall)
        else $error("draw transaction did not occupy the block");

    // A seed load finishes at once and leaves the block ready.
    a_seed_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation |=> !o_in_stall)
        else $error("seed transaction kept the block busy");

    // A new result only appears at the end of a draw.
    a_result_from_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a draw in progress");

endmodule

bind lcg_log_uniform_random llur_chk u_llur_chk (.*);
